FILE: src/ddrs_pkg.sv
// Shared constants, types and pin-change logic for the dual door release sequencer.
// No dependencies; imported by dual_door_release_sequencer_top and the bench.
package ddrs_pkg;

    // stream and register port widths
    localparam int S_TDATA_BITS  = 16;
    localparam int M_TDATA_BITS  = 8;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;
    localparam int DELAY_BITS    = 16;

    // hold time switch and table
    localparam int HOLD_TABLE_ENTRIES = 16;
    localparam int HOLD_SEL_BITS      = 4;
    localparam int HOLD_SEC_BITS      = 7;
    localparam int HOLD_MS_BITS       = 17;
    localparam int MS_PER_SEC         = 1000;

    // upper bound on chained actions within one tick
    localparam int RUN_STEPS = 8;

    // register reset values
    localparam logic [DELAY_BITS-1:0] DIFF_DELAY_RST   = 16'd500;
    localparam logic [DELAY_BITS-1:0] SIGNAL_DELAY_RST = 16'd600;
    localparam logic [DELAY_BITS-1:0] DEBOUNCE_RST     = 16'd255;

    typedef enum logic [1:0] {
        REG_DIFF_DELAY   = 2'd0,
        REG_SIGNAL_DELAY = 2'd1,
        REG_DEBOUNCE     = 2'd2
    } t_reg_idx;

    // latched pin positions
    localparam int PIN_MODE = 0;
    localparam int PIN_TOG1 = 1;
    localparam int PIN_TOG2 = 2;
    localparam int PIN_POL1 = 3;
    localparam int PIN_POL2 = 4;
    localparam int PIN_BITS = 5;

    // output register positions: doors then signals
    localparam int OUT_DOOR1 = 0;
    localparam int OUT_DOOR2 = 1;
    localparam int OUT_SIG1  = 2;
    localparam int OUT_SIG2  = 3;

    typedef logic [HOLD_SEC_BITS-1:0] t_hold_sec;

    localparam t_hold_sec HOLD_SECONDS [HOLD_TABLE_ENTRIES] = '{
        7'd1,  7'd2,  7'd5,  7'd10, 7'd15, 7'd20, 7'd25, 7'd30,
        7'd35, 7'd40, 7'd45, 7'd50, 7'd55, 7'd60, 7'd90, 7'd120
    };

    function automatic logic [HOLD_MS_BITS-1:0] hold_ms(logic [HOLD_SEL_BITS-1:0] sel);
        return HOLD_MS_BITS'(int'(HOLD_SECONDS[sel]) * MS_PER_SEC);
    endfunction

    typedef struct packed {
        logic [PIN_BITS-1:0] latched;
        logic [1:0]          toggled;
        logic [1:0]          timed;
        logic                retract;
        logic [3:0]          outreg;
    } t_flags;

    // Bring latched pins up to date and apply the side effects of each change.
    function automatic t_flags apply_pins(t_flags f, logic [PIN_BITS-1:0] pins);
        logic [PIN_BITS-1:0] chg;
        t_flags              r;
        r   = f;
        chg = pins ^ f.latched;
        if (chg[PIN_MODE]) begin
            r.latched[PIN_MODE] = pins[PIN_MODE];
            r.outreg  = '0;
            r.toggled = '0;
            r.timed   = '0;
            r.retract = 1'b0;
        end
        for (int d = 0; d < 2; d++) begin
            if (chg[PIN_POL1+d]) begin
                r.latched[PIN_POL1+d] = pins[PIN_POL1+d];
                r.outreg[d] = r.timed[d] | r.toggled[d] | r.retract;
            end
        end
        if (chg[PIN_TOG1]) begin
            r.latched[PIN_TOG1] = pins[PIN_TOG1];
            if (r.toggled[0] && r.latched[PIN_TOG1]) begin
                r.outreg[OUT_DOOR1] = 1'b0;
                r.outreg[OUT_SIG1]  = 1'b0;
                r.toggled[0]        = 1'b0;
                if (r.latched[PIN_MODE]) begin
                    r.outreg[OUT_DOOR2] = 1'b0;
                    r.outreg[OUT_SIG2]  = 1'b0;
                    r.toggled[1]        = 1'b0;
                end
            end
        end
        if (chg[PIN_TOG2]) begin
            r.latched[PIN_TOG2] = pins[PIN_TOG2];
            if (r.toggled[1] && r.latched[PIN_TOG2] && !r.latched[PIN_MODE]) begin
                r.outreg[OUT_DOOR2] = 1'b0;
                r.outreg[OUT_SIG2]  = 1'b0;
                r.toggled[1]        = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

FILE: src/dual_door_release_sequencer_top.sv
// Top level of the dual door release sequencer: tick stream in, door/signal levels out.
// Depends on ddrs_pkg (constants, hold table, pin-change logic).
//
// Usage:
//   Each item on the s_axis channel is one 1 ms tick carrying the raw pin levels
//   (mode, toggle, polarity, button pins and the two hold-time switches). For each
//   tick the block returns exactly one item on m_axis with both door drive levels
//   (polarity applied) and both signal outputs.
//   The three delay registers (door-to-door, door-to-signal, debounce, all in ms)
//   sit on the APB port at byte addresses 0, 4 and 8; write them only while idle.
//   The result of a tick is on m_axis in the cycle after the tick is taken.
//   Throughput: one tick per cycle unless m_axis stalls. The whole tick update
//   (pin changes, phase countdown, chained sequencer actions) is one pass of
//   combinational logic between state registers, so the next tick can follow at once.
//   Stall: the result sits in an output register; s_axis_tready stays high while
//   that register is empty or being drained, and drops only while a result waits
//   and m_axis_tready is low. No tick is lost or repeated.
//   Reset (synchronous, active low): phase idle, all doors and signals logically
//   inactive, hold timers zero, registers at 500/600/255 ms. Pin levels are
//   latched from the first tick after reset without side effects.
module dual_door_release_sequencer_top #(
    parameter int HOLD_TIMER_BITS = 17
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tdata: [0] mode_level, [1] toggle1_level, [2] toggle2_level,
    // [3] polarity1_level, [4] polarity2_level, [5] button1_level,
    // [6] button2_level, [10:7] hold_select1, [14:11] hold_select2, [15] zero
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [ddrs_pkg::S_TDATA_BITS-1:0]    s_axis_tdata,
    // tdata: [0] door1_drive, [1] door2_drive, [2] signal1_on, [3] signal2_on,
    // [7:4] zero
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [ddrs_pkg::M_TDATA_BITS-1:0]    m_axis_tdata,
    // register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ddrs_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [ddrs_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [ddrs_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);
    import ddrs_pkg::*;

    // Sequencer phases; the last three codes are transient actions that only
    // live inside one tick's chain and never reach r_phase.
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_DEB1    = 4'd1,
        PH_DEB2    = 4'd2,
        PH_SIG1    = 4'd3,
        PH_SIG2    = 4'd4,
        PH_DIFF    = 4'd5,
        PH_DSIG    = 4'd6,
        PH_HTOG    = 4'd7,
        PH_HTIM    = 4'd8,
        ACT_POLL2  = 4'd9,
        ACT_RETURN = 4'd10,
        ACT_WAIT   = 4'd11
    } t_phase;

    localparam logic [HOLD_TIMER_BITS-1:0] ELAPSED_MAX = {HOLD_TIMER_BITS{1'b1}};

    // config registers
    logic [DELAY_BITS-1:0] r_diff_delay;
    logic [DELAY_BITS-1:0] r_signal_delay;
    logic [DELAY_BITS-1:0] r_debounce;

    // sequencer state
    logic                       r_primed;
    t_flags                     r_flags;
    logic [HOLD_TIMER_BITS-1:0] r_elapsed [2];
    t_phase                     r_phase;
    logic [DELAY_BITS-1:0]      r_count;
    logic                       r_poll;

    // output register
    logic                    r_m_valid;
    logic [3:0]              r_m_data;

    // next-state values
    t_flags                     n_flags;
    logic [HOLD_TIMER_BITS-1:0] n_elapsed [2];
    t_phase                     n_phase;
    logic [DELAY_BITS-1:0]      n_count;
    logic                       n_poll;
    logic [3:0]                 n_result;

    // tick decode and chain scratch
    logic [PIN_BITS-1:0]      c_pins;
    logic [1:0]               c_btn;
    logic [HOLD_SEL_BITS-1:0] c_sel [2];
    t_phase                   c_act;
    logic                     c_dsel;

    logic s_accept;
    logic cfg_write;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {(M_TDATA_BITS - 4)'(0), r_m_data};

    // ---------------- register port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[APB_ADDR_BITS-1:2])
            REG_DIFF_DELAY:   prdata = APB_DATA_BITS'(r_diff_delay);
            REG_SIGNAL_DELAY: prdata = APB_DATA_BITS'(r_signal_delay);
            REG_DEBOUNCE:     prdata = APB_DATA_BITS'(r_debounce);
            default:          prdata = '0;
        endcase
    end

    // ---------------- tick update ----------------
    assign c_pins   = s_axis_tdata[PIN_BITS-1:0];
    assign c_btn    = ~s_axis_tdata[6:5];          // pins read 0 when pressed
    assign c_sel[0] = s_axis_tdata[10:7];
    assign c_sel[1] = s_axis_tdata[14:11];

    always_comb begin
        n_flags      = r_flags;
        n_elapsed[0] = r_elapsed[0];
        n_elapsed[1] = r_elapsed[1];
        n_phase      = r_phase;
        n_count      = r_count;
        n_poll       = r_poll;
        c_act        = ACT_WAIT;
        c_dsel       = 1'b0;

        // first tick after reset only latches the pins
        if (!r_primed) begin
            n_flags.latched = c_pins;
        end

        for (int d = 0; d < 2; d++) begin
            if (n_elapsed[d] != ELAPSED_MAX) begin
                n_elapsed[d] = n_elapsed[d] + 1'b1;
            end
        end

        // pin changes wait while a door/signal phase is in progress
        if (!(n_phase inside {[PH_SIG1:PH_DSIG]})) begin
            n_flags = apply_pins(n_flags, c_pins);
        end

        // per-phase tick work; c_act starts the action chain
        case (n_phase)
            PH_IDLE: begin
                for (int d = 0; d < 2; d++) begin
                    if (n_flags.timed[d] &&
                        n_elapsed[d] >= HOLD_TIMER_BITS'(hold_ms(c_sel[d]))) begin
                        if (c_btn[d]) begin
                            n_elapsed[d] = '0;     // held button restarts the hold
                        end else begin
                            n_flags.outreg[OUT_DOOR1+d] = 1'b0;
                            n_flags.outreg[OUT_SIG1+d]  = 1'b0;
                            n_flags.timed[d]            = 1'b0;
                        end
                    end
                end
                if (c_btn[0] && !n_flags.timed[0]) begin
                    n_poll  = 1'b0;
                    n_phase = PH_DEB1;
                    n_count = r_debounce;
                    c_act   = (r_debounce != '0) ? ACT_WAIT : PH_DEB1;
                end else begin
                    c_act = ACT_POLL2;
                end
            end
            PH_DEB1, PH_DEB2, PH_SIG1, PH_SIG2, PH_DIFF, PH_DSIG: begin
                if (n_count <= DELAY_BITS'(1)) begin
                    n_count = '0;
                    c_act   = n_phase;
                end else begin
                    n_count = n_count - 1'b1;
                end
            end
            PH_HTOG: begin
                if (c_btn == 2'b00) begin
                    c_act = ACT_RETURN;
                end
            end
            PH_HTIM: begin
                if (!n_flags.latched[PIN_MODE] ||
                    n_elapsed[0] > HOLD_TIMER_BITS'(hold_ms(c_sel[0]))) begin
                    n_flags.outreg  = '0;
                    n_flags.retract = 1'b0;
                    c_act           = ACT_RETURN;
                end else if (c_btn != 2'b00) begin
                    n_elapsed[0] = '0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // chained actions: zero delays complete on the same tick
        for (int k = 0; k < RUN_STEPS; k++) begin
            case (c_act)
                ACT_WAIT: begin
                    c_act = ACT_WAIT;
                end
                ACT_POLL2: begin
                    n_poll = 1'b1;
                    if (c_btn[1] && !n_flags.timed[1]) begin
                        n_phase = PH_DEB2;
                        n_count = r_debounce;
                        c_act   = (r_debounce != '0) ? ACT_WAIT : PH_DEB2;
                    end else begin
                        n_phase = PH_IDLE;
                        c_act   = ACT_WAIT;
                    end
                end
                ACT_RETURN: begin
                    if (n_poll) begin
                        n_phase = PH_IDLE;
                        c_act   = ACT_WAIT;
                    end else begin
                        c_act = ACT_POLL2;
                    end
                end
                PH_DEB1, PH_DEB2: begin
                    c_dsel = (c_act == PH_DEB2);
                    if (!c_btn[c_dsel]) begin
                        c_act = ACT_RETURN;
                    end else if (n_flags.latched[PIN_MODE]) begin
                        // dependent: door one first, then door two after diff delay
                        if (!n_flags.latched[PIN_TOG1] && n_flags.toggled[0]) begin
                            n_flags.outreg  = '0;
                            n_flags.toggled = '0;
                            c_act           = ACT_RETURN;
                        end else begin
                            if (!n_flags.latched[PIN_TOG1]) begin
                                n_flags.toggled[0] = 1'b1;
                            end else begin
                                n_flags.retract = 1'b1;
                            end
                            n_flags.outreg[OUT_DOOR1] = 1'b1;
                            n_phase = PH_DIFF;
                            n_count = r_diff_delay;
                            c_act   = (r_diff_delay != '0) ? ACT_WAIT : PH_DIFF;
                        end
                    end else if (!n_flags.latched[c_dsel ? PIN_TOG2 : PIN_TOG1] &&
                                 n_flags.toggled[c_dsel]) begin
                        // independent toggle door switched off
                        n_flags.toggled[c_dsel]  = 1'b0;
                        n_flags.outreg[{1'b0, c_dsel}] = 1'b0;
                        n_flags.outreg[{1'b1, c_dsel}] = 1'b0;
                        c_act = ACT_RETURN;
                    end else begin
                        if (!n_flags.latched[c_dsel ? PIN_TOG2 : PIN_TOG1]) begin
                            n_flags.toggled[c_dsel] = 1'b1;
                        end else begin
                            n_flags.timed[c_dsel] = 1'b1;
                        end
                        n_flags.outreg[{1'b0, c_dsel}] = 1'b1;
                        n_phase = c_dsel ? PH_SIG2 : PH_SIG1;
                        n_count = r_signal_delay;
                        c_act   = (r_signal_delay != '0) ? ACT_WAIT :
                                  (c_dsel ? PH_SIG2 : PH_SIG1);
                    end
                end
                PH_SIG1, PH_SIG2: begin
                    c_dsel = (c_act == PH_SIG2);
                    n_flags.outreg[{1'b1, c_dsel}] = 1'b1;
                    if (n_flags.timed[c_dsel]) begin
                        n_elapsed[c_dsel] = '0;
                    end
                    c_act = ACT_RETURN;
                end
                PH_DIFF: begin
                    n_flags.outreg[OUT_DOOR2] = 1'b1;
                    if (!n_flags.retract) begin
                        n_flags.toggled[1] = 1'b1;
                    end
                    n_phase = PH_DSIG;
                    n_count = r_signal_delay;
                    c_act   = (r_signal_delay != '0) ? ACT_WAIT : PH_DSIG;
                end
                PH_DSIG: begin
                    n_flags.outreg[OUT_SIG1] = 1'b1;
                    n_flags.outreg[OUT_SIG2] = 1'b1;
                    if (n_flags.retract) begin
                        n_elapsed[0] = '0;
                        n_phase      = PH_HTIM;
                    end else begin
                        n_phase = PH_HTOG;
                    end
                    c_act = ACT_WAIT;
                end
                default: begin
                    n_phase = PH_IDLE;
                    c_act   = ACT_WAIT;
                end
            endcase
        end

        if (!(n_phase inside {[PH_SIG1:PH_DSIG]})) begin
            n_flags = apply_pins(n_flags, c_pins);
        end

        // door level: active gives the polarity level, inactive its complement
        n_result[0] = ~(n_flags.outreg[OUT_DOOR1] ^ n_flags.latched[PIN_POL1]);
        n_result[1] = ~(n_flags.outreg[OUT_DOOR2] ^ n_flags.latched[PIN_POL2]);
        n_result[2] = n_flags.outreg[OUT_SIG1];
        n_result[3] = n_flags.outreg[OUT_SIG2];
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_delay   <= DIFF_DELAY_RST;
            r_signal_delay <= SIGNAL_DELAY_RST;
            r_debounce     <= DEBOUNCE_RST;
            r_primed       <= 1'b0;
            r_flags        <= '0;
            r_elapsed[0]   <= '0;
            r_elapsed[1]   <= '0;
            r_phase        <= PH_IDLE;
            r_count        <= '0;
            r_poll         <= 1'b0;
            r_m_valid      <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (paddr[APB_ADDR_BITS-1:2])
                    REG_DIFF_DELAY:   r_diff_delay   <= pwdata[DELAY_BITS-1:0];
                    REG_SIGNAL_DELAY: r_signal_delay <= pwdata[DELAY_BITS-1:0];
                    REG_DEBOUNCE:     r_debounce     <= pwdata[DELAY_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_accept) begin
                r_primed     <= 1'b1;
                r_flags      <= n_flags;
                r_elapsed[0] <= n_elapsed[0];
                r_elapsed[1] <= n_elapsed[1];
                r_phase      <= n_phase;
                r_count      <= n_count;
                r_poll       <= n_poll;
                r_m_valid    <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_m_data <= n_result;
        end
    end

    // ---------------- assertions ----------------
    // every taken tick leaves a result behind
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && s_accept) |=> m_axis_tvalid)
        else $error("tick accepted but no result registered");

    // no countdown left over outside the counted phases
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE || r_phase == PH_HTOG || r_phase == PH_HTIM) |-> (r_count == '0))
        else $error("phase counter nonzero outside a counted phase");

    // door two debounce is reached only through the door two poll
    a_deb2_polled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DEB2) |-> r_poll)
        else $error("door two debounce without poll flag");

endmodule

FILE: verif/tb.sv
// Self-checking bench for dual_door_release_sequencer_top: ms ticks in, door/signal levels out.
// Depends on ddrs_pkg (port widths, register indexes, pin positions, hold table) and the RTL.
`timescale 1ns / 1ps

module tb;
    import ddrs_pkg::*;

    localparam int HOLD_TIMER_BITS = 17;
    localparam int HOLD_CAP        = (1 << HOLD_TIMER_BITS) - 1;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int STALL_AT        = 300;   // results seen before the long output stall
    localparam int STALL_CYCLES    = 400;
    localparam int MAX_PRINTED     = 40;

    // one tick on s_axis, lowest field last
    typedef struct packed {
        logic       spare;
        logic [3:0] sel2;
        logic [3:0] sel1;
        logic       btn2;   // pin levels, 0 = pressed
        logic       btn1;
        logic       pol2;
        logic       pol1;
        logic       tog2;   // 0 = toggle mode
        logic       tog1;
        logic       mode;
    } t_tick;

    // one result on m_axis
    typedef struct packed {
        logic [3:0] spare;
        logic       sig2;
        logic       sig1;
        logic       door2;
        logic       door1;
    } t_levels;

    // sequencer phases, then the chained actions that only live inside one tick
    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_DEB1, SEQ_DEB2, SEQ_SIG1, SEQ_SIG2, SEQ_DIFF, SEQ_DSIG,
        SEQ_HTOG, SEQ_HTIM, ACT_POLL2, ACT_RETURN, ACT_WAIT
    } t_seq;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    // tdata: mode, toggle1, toggle2, pol1, pol2, button1, button2, sel1[3:0], sel2[3:0], zero
    logic [S_TDATA_BITS-1:0]  s_axis_tdata  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // tdata: door1, door2, signal1, signal2, zero[3:0]
    logic [M_TDATA_BITS-1:0]  m_axis_tdata;
    logic                     psel          = 1'b0;
    logic                     penable       = 1'b0;
    logic                     pwrite        = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr         = '0;
    logic [APB_DATA_BITS-1:0] pwdata        = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    dual_door_release_sequencer_top #(
        .HOLD_TIMER_BITS(HOLD_TIMER_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 i_clk = ~i_clk;

    t_tick   tick_queue [$];   // ticks waiting to be offered
    t_levels levels_due [$];   // predicted outputs, oldest first

    int errors        = 0;
    int ticks_taken   = 0;
    int results_seen  = 0;
    int idle_cycles   = 0;
    int send_gap_pct  = 0;
    int recv_gap_pct  = 0;
    int stall_left    = 0;
    bit stall_done    = 1'b0;

    // ------------------------------------------------------------------
    // Door controller model: state, delay registers and one tick of work
    // ------------------------------------------------------------------
    logic [DELAY_BITS-1:0] cfg_diff, cfg_sig, cfg_deb;
    logic [PIN_BITS-1:0]   pin_state, now_pins;
    logic [1:0]            toggled, timed, pressed;
    logic                  retracting, primed, second_polled;
    int                    held_ms [2];
    t_seq                  seq_phase;
    logic [DELAY_BITS-1:0] phase_left;
    logic [3:0]            drive_state;     // door1, door2, sig1, sig2 (logical)
    logic [3:0]            now_sel [2];

    function automatic void reset_controller();
        cfg_diff      = DIFF_DELAY_RST;
        cfg_sig       = SIGNAL_DELAY_RST;
        cfg_deb       = DEBOUNCE_RST;
        pin_state     = '0;
        toggled       = '0;
        timed         = '0;
        retracting    = 1'b0;
        held_ms[0]    = 0;
        held_ms[1]    = 0;
        seq_phase     = SEQ_IDLE;
        phase_left    = '0;
        drive_state   = '0;
        primed        = 1'b0;
        second_polled = 1'b0;
    endfunction

    function automatic int hold_limit(int d);
        return int'(HOLD_SECONDS[now_sel[d]]) * MS_PER_SEC;
    endfunction

    // Latch changed pins and apply their side effects.
    function automatic void follow_pins();
        logic [PIN_BITS-1:0] chg;
        chg = now_pins ^ pin_state;
        if (chg[PIN_MODE]) begin
            pin_state[PIN_MODE] = now_pins[PIN_MODE];
            drive_state = '0;
            toggled     = '0;
            timed       = '0;
            retracting  = 1'b0;
        end
        for (int d = 0; d < 2; d++) begin
            if (chg[PIN_POL1+d]) begin
                pin_state[PIN_POL1+d] = now_pins[PIN_POL1+d];
                drive_state[d] = timed[d] | toggled[d] | retracting;
            end
        end
        if (chg[PIN_TOG1]) begin
            pin_state[PIN_TOG1] = now_pins[PIN_TOG1];
            if (toggled[0] && pin_state[PIN_TOG1]) begin
                drive_state[OUT_DOOR1] = 1'b0;
                drive_state[OUT_SIG1]  = 1'b0;
                toggled[0]             = 1'b0;
                if (pin_state[PIN_MODE]) begin
                    drive_state[OUT_DOOR2] = 1'b0;
                    drive_state[OUT_SIG2]  = 1'b0;
                    toggled[1]             = 1'b0;
                end
            end
        end
        if (chg[PIN_TOG2]) begin
            pin_state[PIN_TOG2] = now_pins[PIN_TOG2];
            if (toggled[1] && pin_state[PIN_TOG2] && !pin_state[PIN_MODE]) begin
                drive_state[OUT_DOOR2] = 1'b0;
                drive_state[OUT_SIG2]  = 1'b0;
                toggled[1]             = 1'b0;
            end
        end
    endfunction

    // Enter a counted phase; a zero count finishes it right away.
    function automatic t_seq start_wait(t_seq ph, logic [DELAY_BITS-1:0] ms);
        seq_phase  = ph;
        phase_left = ms;
        return (phase_left != 0) ? ACT_WAIT : ph;
    endfunction

    // A debounced press on door d.
    function automatic t_seq take_press(int d);
        if (pin_state[PIN_MODE]) begin
            if (!pin_state[PIN_TOG1]) begin
                if (toggled[0]) begin
                    drive_state = '0;
                    toggled     = '0;
                    return ACT_RETURN;
                end
                toggled[0] = 1'b1;
            end else begin
                retracting = 1'b1;
            end
            drive_state[OUT_DOOR1] = 1'b1;
            return start_wait(SEQ_DIFF, cfg_diff);
        end
        if (!pin_state[PIN_TOG1+d]) begin
            toggled[d] = ~toggled[d];
            if (!toggled[d]) begin
                drive_state[d]          = 1'b0;
                drive_state[OUT_SIG1+d] = 1'b0;
                return ACT_RETURN;
            end
        end else begin
            timed[d] = 1'b1;
        end
        drive_state[d] = 1'b1;
        return start_wait(d ? SEQ_SIG2 : SEQ_SIG1, cfg_sig);
    endfunction

    // Follow the chain of actions until something has to wait for a later tick.
    function automatic void chain(t_seq act);
        int d;
        while (1) begin
            case (act)
                ACT_WAIT: return;
                ACT_POLL2: begin
                    second_polled = 1'b1;
                    if (pressed[1] && !timed[1]) begin
                        act = start_wait(SEQ_DEB2, cfg_deb);
                    end else begin
                        seq_phase = SEQ_IDLE;
                        return;
                    end
                end
                ACT_RETURN: begin
                    if (second_polled) begin
                        seq_phase = SEQ_IDLE;
                        return;
                    end
                    act = ACT_POLL2;
                end
                SEQ_DEB1, SEQ_DEB2: begin
                    d   = (act == SEQ_DEB2) ? 1 : 0;
                    act = pressed[d] ? take_press(d) : ACT_RETURN;
                end
                SEQ_SIG1, SEQ_SIG2: begin
                    d = (act == SEQ_SIG2) ? 1 : 0;
                    drive_state[OUT_SIG1+d] = 1'b1;
                    if (timed[d]) held_ms[d] = 0;
                    act = ACT_RETURN;
                end
                SEQ_DIFF: begin
                    drive_state[OUT_DOOR2] = 1'b1;
                    if (!retracting) toggled[1] = 1'b1;
                    act = start_wait(SEQ_DSIG, cfg_sig);
                end
                SEQ_DSIG: begin
                    drive_state[OUT_SIG1] = 1'b1;
                    drive_state[OUT_SIG2] = 1'b1;
                    if (retracting) begin
                        held_ms[0] = 0;
                        seq_phase  = SEQ_HTIM;
                    end else begin
                        seq_phase = SEQ_HTOG;
                    end
                    return;
                end
                default: begin
                    seq_phase = SEQ_IDLE;
                    return;
                end
            endcase
        end
    endfunction

    function automatic void advance_phase();
        t_seq ph;
        ph = seq_phase;
        if (ph == SEQ_IDLE) begin
            // independent timed doors expire here; a held button restarts the hold
            for (int d = 0; d < 2; d++) begin
                if (timed[d] && held_ms[d] >= hold_limit(d)) begin
                    if (pressed[d]) begin
                        held_ms[d] = 0;
                    end else begin
                        drive_state[d]          = 1'b0;
                        drive_state[OUT_SIG1+d] = 1'b0;
                        timed[d]                = 1'b0;
                    end
                end
            end
            if (pressed[0] && !timed[0]) begin
                second_polled = 1'b0;
                chain(start_wait(SEQ_DEB1, cfg_deb));
            end else begin
                chain(ACT_POLL2);
            end
        end else if (ph >= SEQ_DEB1 && ph <= SEQ_DSIG) begin
            if (phase_left <= 1) begin
                phase_left = '0;
                chain(ph);
            end else begin
                phase_left = phase_left - 1'b1;
            end
        end else if (ph == SEQ_HTOG) begin
            if (pressed == 2'b00) chain(ACT_RETURN);
        end else if (ph == SEQ_HTIM) begin
            if (!pin_state[PIN_MODE] || held_ms[0] > hold_limit(0)) begin
                drive_state = '0;
                retracting  = 1'b0;
                chain(ACT_RETURN);
            end else if (pressed != 2'b00) begin
                held_ms[0] = 0;
            end
        end else begin
            seq_phase = SEQ_IDLE;
        end
    endfunction

    function automatic logic is_atomic(t_seq ph);
        return ph >= SEQ_SIG1 && ph <= SEQ_DSIG;
    endfunction

    // One 1 ms tick: returns the expected output levels.
    function automatic t_levels advance_one_ms(t_tick t);
        t_levels r;
        logic    pol;
        now_pins   = {t.pol2, t.pol1, t.tog2, t.tog1, t.mode};
        pressed    = {~t.btn2, ~t.btn1};
        now_sel[0] = t.sel1;
        now_sel[1] = t.sel2;
        if (!primed) begin
            pin_state = now_pins;   // first tick latches without side effects
            primed    = 1'b1;
        end
        for (int d = 0; d < 2; d++)
            if (held_ms[d] < HOLD_CAP) held_ms[d]++;
        if (!is_atomic(seq_phase)) follow_pins();
        advance_phase();
        if (!is_atomic(seq_phase)) follow_pins();
        r   = '0;
        pol = pin_state[PIN_POL1];
        r.door1 = drive_state[OUT_DOOR1] ? pol : ~pol;
        pol = pin_state[PIN_POL2];
        r.door2 = drive_state[OUT_DOOR2] ? pol : ~pol;
        r.sig1  = drive_state[OUT_SIG1];
        r.sig2  = drive_state[OUT_SIG2];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(string what, longint want, longint got);
        errors++;
        // past the cap mismatches are only counted
        if (errors <= MAX_PRINTED)
            $display("mismatch at result %0d: %s expected %0d got %0d",
                     results_seen, what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Tick driver: offers queued ticks, predicts each one as it is taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                levels_due.push_back(advance_one_ms(t_tick'(s_axis_tdata)));
                ticks_taken++;
            end
            // a tick on offer stays put until taken
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tick_queue.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    s_axis_tdata  <= tick_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure plus one long stall so the block backs up
    // and has to drop s_axis_tready while ticks keep being offered.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (!stall_done && results_seen >= STALL_AT) begin
            m_axis_tready <= 1'b0;
            stall_left    <= STALL_CYCLES;
            stall_done    <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_levels want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_levels'(m_axis_tdata);
            if (levels_due.size() == 0) begin
                flag_mismatch("result with nothing expected, tdata", 0, m_axis_tdata);
            end else begin
                want = levels_due.pop_front();
                if (got.door1 !== want.door1) flag_mismatch("door1_drive", want.door1, got.door1);
                if (got.door2 !== want.door2) flag_mismatch("door2_drive", want.door2, got.door2);
                if (got.sig1 !== want.sig1)   flag_mismatch("signal1_on", want.sig1, got.sig1);
                if (got.sig2 !== want.sig2)   flag_mismatch("signal2_on", want.sig2, got.sig2);
            end
            results_seen++;
        end
    end

    // Watchdog: cycles in which neither side moved an item
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void offer(t_tick t, int n);
        repeat (n) tick_queue.push_back(t);
    endfunction

    function automatic t_tick random_tick();
        return t_tick'({1'b0, 15'($urandom)});
    endfunction

    // flip one of the five configuration pins (mode, toggles, polarities)
    function automatic t_tick flip_pin(t_tick t);
        logic [S_TDATA_BITS-1:0] v;
        int                      k;
        v    = t;
        k    = $urandom_range(0, PIN_BITS - 1);
        v[k] = ~v[k];
        return t_tick'(v);
    endfunction

    // Press sequences with random content: a press of one or both buttons,
    // sometimes a pin change mid-press, then a release stretch. Up to
    // 'stretches' releases run past the shortest hold so timed doors expire,
    // sometimes with a tap that can restart the hold. A share of pure noise ticks in
    // between. Every queued tick counts toward 'want'.
    function automatic void queue_episodes(int want, int press_max, int stretches);
        t_tick base, t;
        int    made, len, quiet, twist, poke, which, i;
        base      = random_tick();
        base.btn1 = 1'b1;
        base.btn2 = 1'b1;
        base.sel1 = 4'd0;
        base.sel2 = 4'd0;
        made      = 0;
        while (made < want) begin
            if ($urandom_range(0, 3) == 0) base = flip_pin(base);
            if ($urandom_range(0, 7) == 0) begin
                base.sel1 = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd0;
                base.sel2 = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd0;
            end
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(1, 6);
                repeat (len) tick_queue.push_back(random_tick());
                made += len;
            end else begin
                which  = $urandom_range(1, 3);
                len    = $urandom_range(1, press_max);
                twist  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : -1;
                t      = base;
                t.btn1 = (which & 1) ? 1'b0 : 1'b1;
                t.btn2 = (which & 2) ? 1'b0 : 1'b1;
                for (i = 0; i < len; i++) begin
                    if (i == twist) t = flip_pin(t);
                    tick_queue.push_back(t);
                end
                quiet = (stretches > 0 && $urandom_range(0, 3) == 0)
                        ? $urandom_range(1000, 1300) : $urandom_range(1, 30);
                if (quiet >= 1000) stretches--;
                poke  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, quiet - 1) : -1;
                for (i = 0; i < quiet; i++) begin
                    t.btn1 = !(poke >= 0 && i >= poke && i < poke + 3 && (which & 1));
                    t.btn2 = !(poke >= 0 && i >= poke && i < poke + 3 && (which & 2));
                    tick_queue.push_back(t);
                end
                made += len + quiet;
            end
        end
    endfunction

    // APB access; a read compares against the value given
    task automatic reg_access(logic wr, t_reg_idx idx, logic [APB_DATA_BITS-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (!wr && prdata !== val) flag_mismatch(idx.name(), val, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_delays(logic [DELAY_BITS-1:0] diff, logic [DELAY_BITS-1:0] sig,
                              logic [DELAY_BITS-1:0] deb);
        reg_access(1'b1, REG_DIFF_DELAY, 32'(diff));
        reg_access(1'b1, REG_SIGNAL_DELAY, 32'(sig));
        reg_access(1'b1, REG_DEBOUNCE, 32'(deb));
        reg_access(1'b0, REG_DIFF_DELAY, 32'(diff));
        reg_access(1'b0, REG_SIGNAL_DELAY, 32'(sig));
        reg_access(1'b0, REG_DEBOUNCE, 32'(deb));
        cfg_diff = diff;
        cfg_sig  = sig;
        cfg_deb  = deb;
    endtask

    // wait until every queued tick is taken and every result has come back
    task automatic drain();
        while (tick_queue.size() != 0 || s_axis_tvalid || levels_due.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        t_tick t;
        reset_controller();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values read back
        reg_access(1'b0, REG_DIFF_DELAY, 32'(DIFF_DELAY_RST));
        reg_access(1'b0, REG_SIGNAL_DELAY, 32'(SIGNAL_DELAY_RST));
        reg_access(1'b0, REG_DEBOUNCE, 32'(DEBOUNCE_RST));

        // Directed, all delays zero so every step completes on its own tick
        set_delays(16'd0, 16'd0, 16'd0);
        send_gap_pct = 28;
        recv_gap_pct = 68;
        t      = '0;
        t.tog1 = 1'b1;
        t.tog2 = 1'b1;
        t.pol1 = 1'b1;
        t.pol2 = 1'b1;
        t.btn1 = 1'b1;
        t.btn2 = 1'b1;
        offer(t, 2);                                        // first tick latches pins
        t.btn1 = 1'b0; offer(t, 1); t.btn1 = 1'b1; offer(t, 1); // timed door one
        t.pol1 = 1'b0; t.sel1 = 4'hf; t.sel2 = 4'hf;
        offer(t, 1);                                        // polarity flip while active
        t.tog2 = 1'b0; t.btn2 = 1'b0; offer(t, 1); t.btn2 = 1'b1; offer(t, 1); // toggle on
        t.btn2 = 1'b0; offer(t, 1); t.btn2 = 1'b1; offer(t, 1);                // toggle off
        t.btn2 = 1'b0; offer(t, 1); t.btn2 = 1'b1; offer(t, 1);
        t.tog2 = 1'b1; offer(t, 1);                         // toggle mode dropped while on
        t.mode = 1'b1; t.tog1 = 1'b0; t.pol2 = 1'b0;
        offer(t, 1);                                        // mode change clears all
        t.btn1 = 1'b0; offer(t, 1); t.btn1 = 1'b1; offer(t, 1); // dependent toggle sequence
        t.btn2 = 1'b0; offer(t, 1); t.btn2 = 1'b1; offer(t, 1); // door two button turns it off
        t.btn1 = 1'b0; offer(t, 1); t.btn1 = 1'b1; offer(t, 1);
        t.tog1 = 1'b1; offer(t, 1);                         // toggle one dropped, both doors
        t.btn1 = 1'b0; offer(t, 1);                         // dependent timed hold
        t.btn2 = 1'b0; offer(t, 1);                         // held buttons restart it
        t.btn1 = 1'b1; t.btn2 = 1'b1; offer(t, 1);
        t.mode = 1'b0; offer(t, 1);                         // mode drop ends the hold
        offer('0, 2);                                       // every pin low
        t       = '1;
        t.spare = 1'b0;
        offer(t, 1);                                        // every pin high, top selects
        drain();

        // Random phase one: both sides idle, long output stall somewhere inside,
        // one release long enough for timed doors to expire
        set_delays(16'd4, 16'd3, 16'd2);
        queue_episodes(1500, 12, 1);
        drain();

        // Random phase two: idling swapped
        send_gap_pct = 68;
        recv_gap_pct = 28;
        set_delays(16'd1, 16'd0, 16'd5);
        queue_episodes(300, 12, 0);
        drain();

        // Random phase three: full rate both ways
        send_gap_pct = 0;
        recv_gap_pct = 0;
        set_delays(16'd7, 16'd2, 16'd0);
        queue_episodes(250, 14, 0);
        drain();

        // Largest delays: one press held partway into the full debounce count
        set_delays(16'hffff, 16'hffff, 16'hffff);
        t      = '0;
        t.tog1 = 1'b1;
        t.tog2 = 1'b1;
        t.pol1 = 1'b1;
        t.btn2 = 1'b1;
        offer(t, 40);
        t.pol2 = 1'b1;                                      // polarity change mid-count
        offer(t, 40);
        t.btn1 = 1'b1;
        offer(t, 3);
        drain();

        repeat (4) @(posedge i_clk);
        if (levels_due.size() != 0)
            flag_mismatch("results never delivered, count", 0, levels_due.size());

        $display("run covered %0d ticks and %0d results over five delay settings,",
                 ticks_taken, results_seen);
        $display("with zero and full-scale delays, idle gaps on both sides and a long stall");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
